// File: src/assert_macros.svh
// Assertion macros shared by the list RTL; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/iiel_pkg.sv
// Shared constants, operation codes and cell control type for the indexed list.
package iiel_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF    = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int ITEM_W = 32;
  localparam int LEN_W  = 6;
  localparam int RD_W   = 32;

  // List operations
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT_AT  = 3'd4,
    OP_ERASE_AT   = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_READ_AT    = 3'd7
  } op_t;

  // Result status codes
  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic ins;   // open a gap at the index and write the new value there
    logic ers;   // close the gap at the index by pulling from the right
  } cell_ctrl_t;

endpackage

// File: src/iiel_cell.sv
// One list slot: holds an entry, shifts with its neighbours, forwards the read bus.
`include "assert_macros.svh"

module iiel_cell #(
  parameter int INDEX = 0,
  parameter int IW    = 5,
  parameter int VW    = 32
) (
  input  logic                    clk,
  input  iiel_pkg::cell_ctrl_t    ctrl,
  input  logic [IW-1:0]           at,
  input  logic [IW-1:0]           rd_at,
  input  logic [VW-1:0]           new_value,
  input  logic [VW-1:0]           left_value,
  input  logic [VW-1:0]           right_value,
  input  logic [VW-1:0]           rd_in,
  output logic [VW-1:0]           value,
  output logic [VW-1:0]           rd_out
);

  localparam logic [IW-1:0] ME = IW'(INDEX);

  // Slot storage: shift up on insert, shift down on erase
  always_ff @(posedge clk) begin
    if (ctrl.ins && (ME > at)) begin
      value <= left_value;
    end else if (ctrl.ins && (ME == at)) begin
      value <= new_value;
    end else if (ctrl.ers && (ME >= at)) begin
      value <= right_value;
    end
  end

  // Read bus: the matching cell drives its entry, the rest pass it toward cell 0
  always_ff @(posedge clk) begin
    rd_out <= (ME == rd_at) ? value : rd_in;
  end

endmodule

// File: src/iiel_ctrl.sv
// Sequencer: validates each operation, keeps the length and holds the result beat.
`include "assert_macros.svh"

module iiel_ctrl #(
  parameter int CAPACITY    = iiel_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = iiel_pkg::VALUE_WIDTH_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int VW = VALUE_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [iiel_pkg::OP_W-1:0]  operation,
  input  logic [iiel_pkg::POS_W-1:0] position,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       status,
  output logic [iiel_pkg::LEN_W-1:0] length,
  output logic [iiel_pkg::RD_W-1:0]  read_value,
  input  logic [VW-1:0]              rd_head,
  output iiel_pkg::cell_ctrl_t       cell_ctrl,
  output logic [IW-1:0]              at,
  output logic [IW-1:0]              rd_at
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > iiel_pkg::POS_W) ? CW : iiel_pkg::POS_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [IW-1:0]   rd_cnt;
  logic [PW-1:0]   pos_ext;
  logic [PW-1:0]   cnt_ext;
  logic [PW-1:0]   at_ext;
  logic            not_full;
  logic            not_empty;
  logic            acc;
  logic            ok;
  logic            ins;
  logic            ers;
  logic            start_rd;
  logic            rsp_free;
  logic            ld_now;
  logic            ld_rd;

  // Handshake
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign acc       = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Operation decode and range checks
  always_comb begin
    pos_ext    = PW'(position);
    cnt_ext    = PW'(count);
    not_full   = cnt_ext < CAP_P;
    not_empty  = (count != '0);
    ok         = 1'b0;
    ins        = 1'b0;
    ers        = 1'b0;
    start_rd   = 1'b0;
    at_ext     = pos_ext;
    count_next = count;
    case (iiel_pkg::op_t'(operation))
      iiel_pkg::OP_PUSH_BACK: begin
        ok     = not_full;
        ins    = ok;
        at_ext = cnt_ext;
      end
      iiel_pkg::OP_POP_BACK: begin
        ok = not_empty;
      end
      iiel_pkg::OP_PUSH_FRONT: begin
        ok     = not_full;
        ins    = ok;
        at_ext = '0;
      end
      iiel_pkg::OP_POP_FRONT: begin
        ok     = not_empty;
        ers    = ok;
        at_ext = '0;
      end
      iiel_pkg::OP_INSERT_AT: begin
        ok  = not_full && (pos_ext <= cnt_ext);
        ins = ok;
      end
      iiel_pkg::OP_ERASE_AT: begin
        ok  = pos_ext < cnt_ext;
        ers = ok;
      end
      iiel_pkg::OP_CLEAR: begin
        ok = 1'b1;
      end
      iiel_pkg::OP_READ_AT: begin
        ok       = pos_ext < cnt_ext;
        start_rd = ok;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    // Length after the operation
    if (iiel_pkg::op_t'(operation) == iiel_pkg::OP_CLEAR) begin
      count_next = '0;
    end else if (ins) begin
      count_next = count + CW'(1);
    end else if (ok && ((iiel_pkg::op_t'(operation) == iiel_pkg::OP_POP_BACK) ||
                        ers)) begin
      count_next = count - CW'(1);
    end
  end

  assign at            = at_ext[IW-1:0];
  assign cell_ctrl.ins = acc && ins;
  assign cell_ctrl.ers = acc && ers;

  assign ld_now = acc && !start_rd;
  assign ld_rd  = (state == S_DONE) && rsp_free;

  // Read walk: wait until the matching entry reaches cell 0
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc && start_rd) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (rd_cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (acc) begin
        count <= count_next;
      end
      if (ld_now || ld_rd) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Read index and walk counter
  always_ff @(posedge clk) begin
    if (acc && start_rd) begin
      rd_at  <= at_ext[IW-1:0];
      rd_cnt <= at_ext[IW-1:0];
    end else if (state == S_READ) begin
      rd_cnt <= rd_cnt - IW'(1);
    end
  end

  // Result beat register
  always_ff @(posedge clk) begin
    if (ld_now) begin
      status     <= ok ? iiel_pkg::ST_DONE : iiel_pkg::ST_ERROR;
      length     <= iiel_pkg::LEN_W'(count_next);
      read_value <= '0;
    end else if (ld_rd) begin
      status     <= iiel_pkg::ST_DONE;
      length     <= iiel_pkg::LEN_W'(count);
      read_value <= iiel_pkg::RD_W'(rd_head);
    end
  end

  `ASSERT_ALWAYS(a_count_cap, clk, rst, count <= CW'(CAPACITY), "length above capacity")
  `ASSERT_ALWAYS(a_ins_room, clk, rst, !cell_ctrl.ins || (cnt_ext < CAP_P), "insert on full list")
  `ASSERT_NEXT(a_err_keeps, clk, rst, acc && !ok, count == $past(count), "failed op changed length")
  `ASSERT_NEXT(a_busy_count, clk, rst, state != S_IDLE, $stable(count), "length moved during read")

endmodule

// File: src/indexed_insert_erase_list.sv
// Top level of the indexed list: control sequencer and a chain of slot cells.
//
//   Channel  Valid      Stall      Beat fields
//   request  req_valid  req_stall  operation, position, item_value
//   response rsp_valid  rsp_stall  status, length, read_value
//
// All operations but read_at finish in the cycle they are accepted; the result
// beat appears the next cycle and a new request can be taken in that same cycle.
// A successful read_at holds the request side until its result beat is loaded:
// the read bus moves one cell per cycle from the matching slot to cell 0, and the
// beat is loaded once the entry has reached cell 0.
// Reset (synchronous, active high) empties the list; slot contents are not cleared.
// A stalled response holds the request side only while the result register is full.
module indexed_insert_erase_list #(
  parameter int CAPACITY    = iiel_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = iiel_pkg::VALUE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic [iiel_pkg::OP_W-1:0]   operation,
  input  logic [iiel_pkg::POS_W-1:0]  position,
  input  logic [iiel_pkg::ITEM_W-1:0] item_value,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        status,
  output logic [iiel_pkg::LEN_W-1:0]  length,
  output logic [iiel_pkg::RD_W-1:0]   read_value
);

  localparam int IW = $clog2(CAPACITY);
  localparam int VW = VALUE_WIDTH;

  iiel_pkg::cell_ctrl_t cell_ctrl;
  logic [IW-1:0]        at;
  logic [IW-1:0]        rd_at;
  logic [VW-1:0]        new_value;
  logic [VW-1:0]        vals    [CAPACITY];
  logic [VW-1:0]        rd_bus  [CAPACITY];
  logic [VW-1:0]        left_w  [CAPACITY];
  logic [VW-1:0]        right_w [CAPACITY];
  logic [VW-1:0]        rdin_w  [CAPACITY];

  assign new_value = VW'(item_value);

  iiel_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .position   (position),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .length     (length),
    .read_value (read_value),
    .rd_head    (rd_bus[0]),
    .cell_ctrl  (cell_ctrl),
    .at         (at),
    .rd_at      (rd_at)
  );

  // Chain of slot cells, neighbours wired left and right
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_w[i] = '0;
    end else begin : g_left
      assign left_w[i] = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w[i] = '0;
      assign rdin_w[i]  = '0;
    end else begin : g_right
      assign right_w[i] = vals[i+1];
      assign rdin_w[i]  = rd_bus[i+1];
    end

    iiel_cell #(
      .INDEX (i),
      .IW    (IW),
      .VW    (VW)
    ) u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl),
      .at          (at),
      .rd_at       (rd_at),
      .new_value   (new_value),
      .left_value  (left_w[i]),
      .right_value (right_w[i]),
      .rd_in       (rdin_w[i]),
      .value       (vals[i]),
      .rd_out      (rd_bus[i])
    );
  end

endmodule

// File: tb/iiel_list_checker.sv
`timescale 1ns / 100ps
// Beat monitor for the indexed list: keeps a shadow list, predicts each result and checks it.
module iiel_list_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  input  logic                        req_stall,
  input  logic [iiel_pkg::OP_W-1:0]   operation,
  input  logic [iiel_pkg::POS_W-1:0]  position,
  input  logic [iiel_pkg::ITEM_W-1:0] item_value,
  input  logic                        rsp_valid,
  input  logic                        rsp_stall,
  input  logic                        status,
  input  logic [iiel_pkg::LEN_W-1:0]  length,
  input  logic [iiel_pkg::RD_W-1:0]   read_value,
  output int                          fail_count,
  output int                          pending_results,
  output int                          list_length
);

  localparam int LIST_DEPTH = iiel_pkg::CAPACITY_DEF;

  typedef struct packed {
    logic                       status;
    logic [iiel_pkg::LEN_W-1:0] length;
    logic [iiel_pkg::RD_W-1:0]  read_value;
  } list_result_t;

  // Shadow copy of the list contents, index 0 at the front
  logic [iiel_pkg::ITEM_W-1:0] entries[$];
  // Results owed by the block, oldest first
  list_result_t                owed_results[$];

  // Apply one operation to the shadow list and return the result it should give.
  // A failing operation leaves the list alone.
  function automatic list_result_t apply_list_op(iiel_pkg::op_t op,
                                                 logic [iiel_pkg::POS_W-1:0] pos,
                                                 logic [iiel_pkg::ITEM_W-1:0] val);
    list_result_t res;
    logic         ok;
    res = '0;
    case (op)
      iiel_pkg::OP_PUSH_BACK: begin
        ok = entries.size() < LIST_DEPTH;
        if (ok) entries.push_back(val);
      end
      iiel_pkg::OP_POP_BACK: begin
        ok = entries.size() > 0;
        if (ok) void'(entries.pop_back());
      end
      iiel_pkg::OP_PUSH_FRONT: begin
        ok = entries.size() < LIST_DEPTH;
        if (ok) entries.push_front(val);
      end
      iiel_pkg::OP_POP_FRONT: begin
        ok = entries.size() > 0;
        if (ok) void'(entries.pop_front());
      end
      iiel_pkg::OP_INSERT_AT: begin
        // position equal to the length appends
        ok = entries.size() < LIST_DEPTH && pos <= entries.size();
        if (ok) entries.insert(pos, val);
      end
      iiel_pkg::OP_ERASE_AT: begin
        ok = pos < entries.size();
        if (ok) entries.delete(pos);
      end
      iiel_pkg::OP_CLEAR: begin
        entries.delete();
        ok = 1'b1;
      end
      default: begin
        // read at index; value is zero unless the read succeeds
        ok = pos < entries.size();
        if (ok) res.read_value = entries[pos];
      end
    endcase
    res.status = ok ? iiel_pkg::ST_DONE : iiel_pkg::ST_ERROR;
    res.length = iiel_pkg::LEN_W'(entries.size());
    return res;
  endfunction

  function automatic void check_field(string name, logic [iiel_pkg::RD_W-1:0] want,
                                      logic [iiel_pkg::RD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Response beats are checked before the request of the same edge is predicted
  always @(posedge clk) begin : watch_beats
    list_result_t seen;
    list_result_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        seen = {status, length, read_value};
        if (owed_results.size() == 0) begin
          $display("%0t ns: response beat with none owed, got status %0b length %0d value 0x%0h",
                   $time, seen.status, seen.length, seen.read_value);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", iiel_pkg::RD_W'(want.status), iiel_pkg::RD_W'(seen.status));
          check_field("length", iiel_pkg::RD_W'(want.length), iiel_pkg::RD_W'(seen.length));
          check_field("read_value", want.read_value, seen.read_value);
        end
      end
      if (req_valid && !req_stall)
        owed_results.push_back(apply_list_op(iiel_pkg::op_t'(operation), position,
                                             item_value));
    end
    pending_results = owed_results.size();
    list_length     = entries.size();
  end

endmodule

// File: tb/tb_indexed_insert_erase_list.sv
`timescale 1ns / 100ps
// Testbench top for the indexed list: clock, reset, request beats, response stalls, verdict.
module tb_indexed_insert_erase_list;

  localparam int CLK_PERIOD      = 10;
  localparam int LIST_DEPTH      = iiel_pkg::CAPACITY_DEF;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int FILL_BEATS      = 40;
  localparam int RANDOM_BEATS    = 430;
  localparam int SETTLE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                        clk = 1'b0;
  logic                        rst;
  logic                        req_valid;
  logic                        req_stall;
  logic [iiel_pkg::OP_W-1:0]   operation;
  logic [iiel_pkg::POS_W-1:0]  position;
  logic [iiel_pkg::ITEM_W-1:0] item_value;
  logic                        rsp_valid;
  logic                        rsp_stall;
  logic                        status;
  logic [iiel_pkg::LEN_W-1:0]  length;
  logic [iiel_pkg::RD_W-1:0]   read_value;

  int fail_count;
  int pending_results;
  int list_length;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  bit hold_off_req;
  bit filling = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  indexed_insert_erase_list DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .operation  (operation),
    .position   (position),
    .item_value (item_value),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .length     (length),
    .read_value (read_value)
  );

  iiel_list_checker u_list_checker (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .operation       (operation),
    .position        (position),
    .item_value      (item_value),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .length          (length),
    .read_value      (read_value),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .list_length     (list_length)
  );

  // Response side: random stalls, or one long hold-off when asked for
  initial begin : response_side
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
    end
  end

  // Watchdog: too long without a beat on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Move to the next falling edge, idling the request side at random.
  // Payload is scrambled while valid is low.
  task automatic next_slot();
    @(negedge clk);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_valid  <= 1'b0;
      operation  <= iiel_pkg::OP_W'($urandom_range(7, 0));
      position   <= iiel_pkg::POS_W'($urandom);
      item_value <= iiel_pkg::ITEM_W'($urandom);
      @(negedge clk);
    end
  endtask

  // Present a beat at the current falling edge and hold it until taken
  task automatic drive_beat(input iiel_pkg::op_t op, input logic [iiel_pkg::POS_W-1:0] pos,
                            input logic [iiel_pkg::ITEM_W-1:0] val);
    req_valid  <= 1'b1;
    operation  <= op;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic put(input iiel_pkg::op_t op, input logic [iiel_pkg::POS_W-1:0] pos,
                     input logic [iiel_pkg::ITEM_W-1:0] val);
    next_slot();
    drive_beat(op, pos, val);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain_results();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  function automatic iiel_pkg::op_t grow_op();
    case ($urandom_range(2, 0))
      0:       return iiel_pkg::OP_PUSH_BACK;
      1:       return iiel_pkg::OP_PUSH_FRONT;
      default: return iiel_pkg::OP_INSERT_AT;
    endcase
  endfunction

  function automatic iiel_pkg::op_t shrink_op();
    case ($urandom_range(2, 0))
      0:       return iiel_pkg::OP_POP_BACK;
      1:       return iiel_pkg::OP_POP_FRONT;
      default: return iiel_pkg::OP_ERASE_AT;
    endcase
  endfunction

  // Mostly in range for the current length, sometimes anywhere in the field
  function automatic logic [iiel_pkg::POS_W-1:0] pick_position(iiel_pkg::op_t op);
    if ($urandom_range(9, 0) < 2) return iiel_pkg::POS_W'($urandom_range(63, 0));
    if (op == iiel_pkg::OP_INSERT_AT) return iiel_pkg::POS_W'($urandom_range(list_length, 0));
    return (list_length == 0) ? '0 : iiel_pkg::POS_W'($urandom_range(list_length - 1, 0));
  endfunction

  function automatic logic [iiel_pkg::ITEM_W-1:0] pick_value();
    case ($urandom_range(19, 0))
      0:       return '1;
      1:       return '0;
      default: return iiel_pkg::ITEM_W'($urandom);
    endcase
  endfunction

  // Length drifts between empty and full so every depth gets exercised
  task automatic random_beat();
    iiel_pkg::op_t op;
    int            roll;
    next_slot();
    if (list_length >= LIST_DEPTH) filling = 1'b0;
    else if (list_length == 0) filling = 1'b1;
    roll = $urandom_range(99, 0);
    if (roll < 1)
      op = iiel_pkg::OP_CLEAR;
    else if (roll < 13)
      op = iiel_pkg::OP_READ_AT;
    else if ($urandom_range(99, 0) < (filling ? 80 : 20))
      op = grow_op();
    else
      op = shrink_op();
    drive_beat(op, pick_position(op), pick_value());
  endtask

  task automatic run_random(input int beats, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (beats) random_beat();
    drain_results();
  endtask

  initial begin : stimulus
    rst           = 1'b1;
    req_valid     = 1'b0;
    operation     = iiel_pkg::OP_PUSH_BACK;
    position      = '0;
    item_value    = '0;
    send_idle_pct = 26;
    recv_idle_pct = 56;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty list: pops, erase, read and insert past the end all fail; clear succeeds
    put(iiel_pkg::OP_POP_BACK, 6'd0, 32'h0);
    put(iiel_pkg::OP_POP_FRONT, 6'd0, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd0, 32'h0);
    put(iiel_pkg::OP_ERASE_AT, 6'd0, 32'h0);
    put(iiel_pkg::OP_INSERT_AT, 6'd1, 32'h1111_1111);
    put(iiel_pkg::OP_CLEAR, 6'd0, 32'h0);
    // Build [0, A5.., FF.., 5A..], the last by insert at the length
    put(iiel_pkg::OP_PUSH_BACK, 6'd0, 32'hFFFF_FFFF);
    put(iiel_pkg::OP_PUSH_FRONT, 6'd0, 32'h0000_0000);
    put(iiel_pkg::OP_INSERT_AT, 6'd1, 32'hA5A5_A5A5);
    put(iiel_pkg::OP_INSERT_AT, 6'd3, 32'h5A5A_5A5A);
    put(iiel_pkg::OP_INSERT_AT, 6'd5, 32'h2222_2222);
    put(iiel_pkg::OP_READ_AT, 6'd0, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd1, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd2, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd3, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd4, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd63, 32'h0);
    // Erase in the middle, then at and beyond the end
    put(iiel_pkg::OP_ERASE_AT, 6'd1, 32'h0);
    put(iiel_pkg::OP_ERASE_AT, 6'd3, 32'h0);
    put(iiel_pkg::OP_ERASE_AT, 6'd63, 32'h0);
    put(iiel_pkg::OP_POP_FRONT, 6'd0, 32'h0);
    put(iiel_pkg::OP_POP_BACK, 6'd0, 32'h0);
    put(iiel_pkg::OP_CLEAR, 6'd0, 32'h0);
    drain_results();

    // Long response hold-off while the list fills up to capacity
    put(iiel_pkg::OP_CLEAR, 6'd0, 32'h0);
    hold_off_req = 1'b1;
    repeat (FILL_BEATS) begin
      iiel_pkg::op_t op;
      next_slot();
      op = grow_op();
      drive_beat(op, pick_position(op), pick_value());
    end
    // Full list: every push fails; deepest read and erase at the last index
    put(iiel_pkg::OP_PUSH_BACK, 6'd0, 32'h3333_3333);
    put(iiel_pkg::OP_PUSH_FRONT, 6'd0, 32'h4444_4444);
    put(iiel_pkg::OP_INSERT_AT, 6'd32, 32'h5555_5555);
    put(iiel_pkg::OP_READ_AT, 6'd31, 32'h0);
    put(iiel_pkg::OP_READ_AT, 6'd32, 32'h0);
    put(iiel_pkg::OP_ERASE_AT, 6'd31, 32'h0);
    put(iiel_pkg::OP_ERASE_AT, 6'd0, 32'h0);
    drain_results();

    run_random(RANDOM_BEATS, 26, 56);
    run_random(RANDOM_BEATS, 56, 26);
    run_random(RANDOM_BEATS, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
